// File: sv/mmrs_pkg.sv
// Shared types and constants of the row-streaming matrix multiply unit.
`default_nettype none

package mmrs_pkg;

  // Field widths fixed by the item format.
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 32;
  localparam int SUM_W     = 38;
  localparam int IDX_W     = 6;
  localparam int ROW_W     = 12;
  localparam int DIM_W     = 7;
  localparam int ROWS_W    = 13;
  localparam int CFG_IDX_W = 2;

  // Result queue between the engine and the output port.
  localparam int OFIFO_DEPTH = 4;
  localparam int OPTR_W      = 2;
  localparam int OCNT_W      = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd2;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_t;

  // Effective (clamped) dimensions.
  typedef struct packed {
    logic [DIM_W-1:0]  kn;
    logic [DIM_W-1:0]  nn;
    logic [ROWS_W-1:0] mn;
  } dims_t;

  // A classified item on its way from the front to the engine.
  typedef struct packed {
    opcode_t                  op;
    logic [IDX_W-1:0]         k;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] value;
    logic                     last_k;
  } work_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] sum;
    logic                    last_row;
    logic                    last_mat;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN
  } bk_state_t;

endpackage

`default_nettype wire

// File: sv/matrix_multiply_row_stream_unit.sv
// Top level: the engine takes each A element from the queue, sweeps it over the columns
// through the shared multiplier and drains the read/multiply/add pipeline; a row's last
// element also stalls while the result queue has no room. A load item is written into B
// when the engine pops it. A row's results are pushed from the add stage of its last A
// element. Reset (synchronous, active low) sets the registers to 64 and clears queues,
// the row counter and the accumulator valid bits, not B.
`default_nettype none

module matrix_multiply_row_stream_unit import mmrs_pkg::*; #(
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic                     in_opcode,
  input  wire logic [IDX_W-1:0]         in_k_index,
  input  wire logic [IDX_W-1:0]         in_col_index,
  input  wire logic signed [ELEM_W-1:0] in_element_value,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [ROW_W-1:0]              out_row_index,
  output logic [IDX_W-1:0]              out_column,
  output logic signed [SUM_W-1:0]       out_column_sum,
  output logic                          out_last_of_row,
  output logic                          out_last_of_matrix,
  input  wire logic                     valid,
  output logic                          ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ROWS_W-1:0]        cfg_data
);

  localparam int KCAP = (MAX_INNER < 64) ? MAX_INNER : 64;
  localparam int CCAP = (MAX_COLS < 64) ? MAX_COLS : 64;

  logic [DIM_W-1:0]  inner_k_r;
  logic [DIM_W-1:0]  cols_n_r;
  logic [ROWS_W-1:0] rows_m_r;
  dims_t             dims;
  logic              q_valid;
  work_t             q_item;
  logic              q_pop;
  logic [OCNT_W-1:0] ofifo_cnt;
  logic              res_push;
  result_t           res;
  result_t           head;

  // Configuration registers.
  assign ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_k_r <= DIM_W'(64);
      cols_n_r  <= DIM_W'(64);
      rows_m_r  <= ROWS_W'(64);
    end else if (valid && ready) begin
      if (cfg_index == REG_INNER_K) begin
        inner_k_r <= cfg_data[DIM_W-1:0];
      end
      if (cfg_index == REG_COLS_N) begin
        cols_n_r <= cfg_data[DIM_W-1:0];
      end
      if (cfg_index == REG_ROWS_M) begin
        rows_m_r <= cfg_data;
      end
    end
  end

  // Clamp the registers into their working ranges.
  always_comb begin
    if (inner_k_r == '0) begin
      dims.kn = DIM_W'(1);
    end else if (inner_k_r > DIM_W'(KCAP)) begin
      dims.kn = DIM_W'(KCAP);
    end else begin
      dims.kn = inner_k_r;
    end
    if (cols_n_r == '0) begin
      dims.nn = DIM_W'(1);
    end else if (cols_n_r > DIM_W'(CCAP)) begin
      dims.nn = DIM_W'(CCAP);
    end else begin
      dims.nn = cols_n_r;
    end
    if (rows_m_r == '0) begin
      dims.mn = ROWS_W'(1);
    end else if (rows_m_r > ROWS_W'(4096)) begin
      dims.mn = ROWS_W'(4096);
    end else begin
      dims.mn = rows_m_r;
    end
  end

  mmrs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .dims             (dims),
    .push             (push),
    .full             (full),
    .in_opcode        (in_opcode),
    .in_k_index       (in_k_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  mmrs_back #(.MAX_INNER(MAX_INNER), .MAX_COLS(MAX_COLS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .ofifo_cnt (ofifo_cnt),
    .res_push  (res_push),
    .res       (res)
  );

  mmrs_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res      (res),
    .cnt      (ofifo_cnt),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign out_row_index      = head.row;
  assign out_column         = head.col;
  assign out_column_sum     = head.sum;
  assign out_last_of_row    = head.last_row;
  assign out_last_of_matrix = head.last_mat;

`ifndef SYNTH
  // The engine never pushes a result into a full result queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && (ofifo_cnt == OCNT_W'(OFIFO_DEPTH))))
    else $error("result queue overflow");

  // The end of a matrix is always the end of a row.
  a_mat_implies_row: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.last_mat |-> res.last_row)
    else $error("last_of_matrix without last_of_row");

  // After reset no result is waiting.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("results visible after reset");
`endif

endmodule

`default_nettype wire

// File: sv/mmrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mmrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: sv/mmrs_front.sv
// Front end: accepts input items, drops out-of-range ones and queues the rest.
`default_nettype none

module mmrs_front import mmrs_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dims_t                    dims,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic                     in_opcode,
  input  wire logic [IDX_W-1:0]         in_k_index,
  input  wire logic [IDX_W-1:0]         in_col_index,
  input  wire logic signed [ELEM_W-1:0] in_element_value,
  output logic                          q_valid,
  output work_t                         q_item,
  input  wire logic                     q_pop
);

  localparam int QD = 2;

  work_t      q_mem [QD];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;
  logic       keep;
  logic       q_push;
  work_t      item;

  // Classify the incoming item against the current dimensions.
  always_comb begin
    item.op     = opcode_t'(in_opcode);
    item.k      = in_k_index;
    item.col    = in_col_index;
    item.value  = in_element_value;
    item.last_k = ({1'b0, in_k_index} == (dims.kn - DIM_W'(1)));
    keep = ({1'b0, in_k_index} < dims.kn) &&
           ((item.op == OP_COMPUTE) || ({1'b0, in_col_index} < dims.nn));
  end

  assign full    = (cnt_r == 2'(QD));
  assign accept  = push && !full;
  assign q_push  = accept && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_mem[rp_r];

  // Queue pointers and fill count.
  always_comb begin
    wp_nxt  = q_push ? ~wp_r : wp_r;
    rp_nxt  = q_pop  ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(q_push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[wp_r] <= item;
    end
  end

endmodule

`default_nettype wire

// File: sv/mmrs_back.sv
// Engine: stores B elements and sweeps each A element over the columns.
`default_nettype none

module mmrs_back import mmrs_pkg::*; #(
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dims_t             dims,
  input  wire logic              q_valid,
  input  wire work_t             q_item,
  output logic                   q_pop,
  input  wire logic [OCNT_W-1:0] ofifo_cnt,
  output logic                   res_push,
  output result_t                res
);

  localparam int KCAP   = (MAX_INNER < 64) ? MAX_INNER : 64;
  localparam int BDEPTH = KCAP * MAX_COLS;
  localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int CAW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  bk_state_t state_r, state_nxt;

  logic [IDX_W-1:0]         k_r;
  logic [IDX_W-1:0]         col_r;
  logic signed [ELEM_W-1:0] value_r;
  logic                     final_r;
  logic [MAX_COLS-1:0]      vld_r;
  logic [ROW_W-1:0]         row_cnt_r;

  logic                     s1_v_r;
  logic [IDX_W-1:0]         s1_col_r;
  logic                     s1_vld_r;
  logic                     s2_v_r;
  logic [IDX_W-1:0]         s2_col_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic [SUM_W-1:0]         s2_acc_r;

  logic             take;
  logic             b_we;
  logic             issue;
  logic             credit_ok;
  logic             last_issue;
  logic             drain_done;
  logic             row_end;
  logic             acc_we;
  logic             last_mat_row;
  logic [BAW-1:0]   b_waddr;
  logic [BAW-1:0]   b_raddr;
  logic [ELEM_W-1:0] b_rdata;
  logic [SUM_W-1:0] acc_rdata;
  logic [SUM_W-1:0] sum;

  // Store of B, addressed by row k and column.
  assign b_waddr = BAW'(int'(q_item.k) * MAX_COLS + int'(q_item.col));
  assign b_raddr = BAW'(int'(k_r) * MAX_COLS + int'(col_r));

  mmrs_ram #(.WIDTH(ELEM_W), .DEPTH(BDEPTH)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (q_item.value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Column accumulators; an entry without its valid bit reads as zero.
  mmrs_ram #(.WIDTH(SUM_W), .DEPTH(MAX_COLS)) u_acc (
    .clk   (clk),
    .we    (acc_we),
    .waddr (s2_col_r[CAW-1:0]),
    .wdata (sum),
    .raddr (col_r[CAW-1:0]),
    .rdata (acc_rdata)
  );

  // Room in the result queue for everything already in flight.
  assign credit_ok = (int'(ofifo_cnt) + int'(s1_v_r) + int'(s2_v_r)) < OFIFO_DEPTH;
  assign last_issue = ({1'b0, col_r} == (dims.nn - DIM_W'(1)));

  // Control outputs of the sequencer.
  always_comb begin
    q_pop      = (state_r == BK_IDLE) && q_valid;
    b_we       = q_pop && (q_item.op == OP_LOAD);
    take       = q_pop && (q_item.op == OP_COMPUTE);
    issue      = (state_r == BK_RUN) && (!final_r || credit_ok);
    drain_done = (state_r == BK_DRAIN) && !s1_v_r && !s2_v_r;
    row_end    = drain_done && final_r;
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (take) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (issue && last_issue) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (drain_done) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Final stage: add the product to the running sum.
  assign sum          = s2_acc_r + SUM_W'(s2_prod_r);
  assign acc_we       = s2_v_r && !final_r;
  assign res_push     = s2_v_r && final_r;
  assign last_mat_row = ({1'b0, row_cnt_r} >= (dims.mn - ROWS_W'(1)));

  always_comb begin
    res.row      = row_cnt_r;
    res.col      = s2_col_r;
    res.sum      = sum;
    res.last_row = ({1'b0, s2_col_r} == (dims.nn - DIM_W'(1)));
    res.last_mat = res.last_row && last_mat_row;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      vld_r     <= '0;
      row_cnt_r <= '0;
      final_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      if (take) begin
        final_r <= q_item.last_k;
      end
      if (row_end) begin
        vld_r     <= '0;
        row_cnt_r <= last_mat_row ? '0 : row_cnt_r + ROW_W'(1);
      end else if (acc_we) begin
        vld_r[s2_col_r[CAW-1:0]] <= 1'b1;
      end
    end
  end

  // Element registers and column sweep.
  always_ff @(posedge clk) begin
    if (take) begin
      k_r     <= q_item.k;
      value_r <= q_item.value;
      col_r   <= '0;
    end else if (issue) begin
      col_r <= col_r + IDX_W'(1);
    end
  end

  // Pipeline payload: read, multiply, accumulate.
  always_ff @(posedge clk) begin
    s1_col_r  <= col_r;
    s1_vld_r  <= vld_r[col_r[CAW-1:0]];
    s2_col_r  <= s1_col_r;
    s2_prod_r <= value_r * $signed(b_rdata);
    s2_acc_r  <= s1_vld_r ? acc_rdata : '0;
  end

endmodule

`default_nettype wire

// File: sv/mmrs_out_fifo.sv
// Result queue that feeds the output port.
`default_nettype none

module mmrs_out_fifo import mmrs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_push,
  input  wire result_t           res,
  output logic [OCNT_W-1:0]      cnt,
  output logic                   empty,
  input  wire logic              pop,
  output result_t                head
);

  result_t             mem [OFIFO_DEPTH];
  logic [OPTR_W-1:0]   wp_r, rp_r;
  logic [OCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_pop;

  assign empty  = (cnt_r == '0);
  assign do_pop = pop && !empty;
  assign cnt    = cnt_r;
  assign head   = mem[rp_r];

  // Count follows pushes and pops.
  assign cnt_nxt = cnt_r + OCNT_W'(res_push) - OCNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (res_push) begin
        wp_r <= wp_r + OPTR_W'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + OPTR_W'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (res_push) begin
      mem[wp_r] <= res;
    end
  end

endmodule

`default_nettype wire
